// ===== hw/rtl/wasm_instruction_leb128_encoder_core_macros.svh =====
// Assertion macros used by the encoder top level.
`ifndef WASM_INSTRUCTION_LEB128_ENCODER_CORE_MACROS_SVH
`define WASM_INSTRUCTION_LEB128_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WLEB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WLEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wleb_pkg.sv =====
// Types, opcode tables and the request decoder of the instruction encoder.
package wleb_pkg;

  // Stream payload widths.
  localparam int TDATA_IN_W  = 72;
  localparam int TDATA_OUT_W = 40;

  // Action codes.
  localparam logic [5:0] ACT_RAW          = 6'd0;
  localparam logic [5:0] ACT_LEB_U32      = 6'd1;
  localparam logic [5:0] ACT_LEB_S64      = 6'd2;
  localparam logic [5:0] ACT_I64_CONST    = 6'd3;
  localparam logic [5:0] ACT_LOCAL_GET    = 6'd4;
  localparam logic [5:0] ACT_BR_IF        = 6'd7;
  localparam logic [5:0] ACT_BLOCK        = 6'd8;
  localparam logic [5:0] ACT_IF           = 6'd11;
  localparam logic [5:0] ACT_SINGLE_FIRST = 6'd12;
  localparam logic [5:0] ACT_SINGLE_LAST  = 6'd32;

  // Opcode bytes.
  localparam logic [7:0] OP_I64_CONST = 8'h42;
  localparam logic [7:0] INDEX_OPS [4] = '{8'h20, 8'h21, 8'h0c, 8'h0d};
  localparam logic [7:0] BLOCK_LEAD [4] = '{8'h02, 8'h02, 8'h03, 8'h04};
  localparam logic [7:0] BLOCK_TYPE [4] = '{8'h40, 8'h7e, 8'h40, 8'h40};
  localparam logic [7:0] SINGLE_OPS [21] = '{
    8'h7c, 8'h7d, 8'h7e, 8'h7f, 8'h81, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'hac, 8'h1a, 8'h05, 8'h0b, 8'h0f
  };

  typedef enum logic [1:0] {LEB_NONE, LEB_U32, LEB_S64} leb_kind_t;
  typedef enum logic [1:0] {SEL_PRE0, SEL_PRE1, SEL_LEB} byte_sel_t;
  typedef enum logic [1:0] {ST_IDLE, ST_PRE0, ST_PRE1, ST_LEB} state_t;

  // What one request emits: up to two fixed bytes, then an optional LEB128 number.
  typedef struct packed {
    logic [1:0] n_pre;
    leb_kind_t  leb;
    logic [7:0] pre0;
    logic [7:0] pre1;
  } plan_t;

  // Controller to datapath.
  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_t sel;
    logic      last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       out_free;
    logic [1:0] n_pre;
    leb_kind_t  leb;
    logic       leb_final;
  } stat_t;

  // Map an action code to the bytes it emits. Unused codes emit nothing.
  function automatic plan_t decode_action(input logic [5:0] action, input logic [7:0] raw);
    plan_t      p;
    logic [5:0] rel;
    p   = '{n_pre: 2'd0, leb: LEB_NONE, pre0: 8'h00, pre1: 8'h00};
    rel = 6'd0;
    if (action == ACT_RAW) begin
      p.n_pre = 2'd1;
      p.pre0  = raw;
    end else if (action == ACT_LEB_U32) begin
      p.leb = LEB_U32;
    end else if (action == ACT_LEB_S64) begin
      p.leb = LEB_S64;
    end else if (action == ACT_I64_CONST) begin
      p.n_pre = 2'd1;
      p.pre0  = OP_I64_CONST;
      p.leb   = LEB_S64;
    end else if (action <= ACT_BR_IF) begin
      rel     = action - ACT_LOCAL_GET;
      p.n_pre = 2'd1;
      p.pre0  = INDEX_OPS[rel[1:0]];
      p.leb   = LEB_U32;
    end else if (action <= ACT_IF) begin
      rel     = action - ACT_BLOCK;
      p.n_pre = 2'd2;
      p.pre0  = BLOCK_LEAD[rel[1:0]];
      p.pre1  = BLOCK_TYPE[rel[1:0]];
    end else if (action <= ACT_SINGLE_LAST) begin
      rel     = action - ACT_SINGLE_FIRST;
      p.n_pre = 2'd1;
      p.pre0  = SINGLE_OPS[rel[4:0]];
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/wleb_ctrl.sv =====
// Sequencing state machine of the instruction encoder.
module wleb_ctrl
  import wleb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [5:0] action,
  output logic       s_tready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  plan_t  in_plan;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. A byte is only issued when the output register is free.
  always_comb begin
    in_plan    = decode_action(action, 8'h00);
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '{load: 1'b0, emit: 1'b0, sel: SEL_PRE0, last: 1'b0};
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (in_plan.n_pre != 2'd0) begin
            state_next = ST_PRE0;
          end else if (in_plan.leb != LEB_NONE) begin
            state_next = ST_LEB;
          end
        end
      end
      ST_PRE0: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_PRE0;
          cmd.last = (stat.n_pre == 2'd1) && (stat.leb == LEB_NONE);
          if (stat.n_pre == 2'd2) begin
            state_next = ST_PRE1;
          end else if (stat.leb != LEB_NONE) begin
            state_next = ST_LEB;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PRE1: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_PRE1;
          cmd.last = (stat.leb == LEB_NONE);
          state_next = (stat.leb != LEB_NONE) ? ST_LEB : ST_IDLE;
        end
      end
      ST_LEB: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_LEB;
          cmd.last = stat.leb_final;
          if (stat.leb_final) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/wleb_dpath.sv =====
// Datapath of the instruction encoder: request registers, LEB128 shifter,
// byte position counter and output register.
module wleb_dpath
  import wleb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [5:0]             action,
  input  logic signed [63:0]     operand,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  output logic                   m_tlast
);

  plan_t       plan;
  plan_t       load_plan;
  logic [63:0] value;
  logic [63:0] rest;
  logic        leb_final;
  logic [7:0]  leb_byte;
  logic [7:0]  sel_byte;
  logic [31:0] position;
  logic [7:0]  out_byte;
  logic [31:0] out_pos;

  assign load_plan = decode_action(action, operand[7:0]);

  // One LEB128 group: drop seven bits, sign-filled for signed numbers.
  always_comb begin
    if (plan.leb == LEB_S64) begin
      rest      = {{7{value[63]}}, value[63:7]};
      leb_final = ((rest == 64'd0) && !value[6]) || ((rest == '1) && value[6]);
    end else begin
      rest      = {7'd0, value[63:7]};
      leb_final = (rest == 64'd0);
    end
    leb_byte = {~leb_final, value[6:0]};
  end

  // Byte select for the output register.
  always_comb begin
    case (cmd.sel)
      SEL_PRE0: sel_byte = plan.pre0;
      SEL_PRE1: sel_byte = plan.pre1;
      SEL_LEB:  sel_byte = leb_byte;
      default:  sel_byte = plan.pre0;
    endcase
  end

  // Control registers: output valid and running position.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      position <= 32'd0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
        position <= position + 32'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      plan  <= load_plan;
      value <= (load_plan.leb == LEB_U32) ? {32'd0, operand[31:0]} : operand;
    end else if (cmd.emit && (cmd.sel == SEL_LEB)) begin
      value <= rest;
    end
    if (cmd.emit) begin
      out_byte <= sel_byte;
      out_pos  <= position;
      m_tlast  <= cmd.last;
    end
  end

  assign m_tdata = {out_pos, out_byte};

  assign stat = '{out_free:  (~m_tvalid) | m_tready,
                  n_pre:     plan.n_pre,
                  leb:       plan.leb,
                  leb_final: leb_final};

endmodule

// ===== hw/rtl/wasm_instruction_leb128_encoder_core.sv =====
// Top level of the WebAssembly instruction encoder with LEB128 operands.
// Each input transaction is one request (raw byte, bare unsigned-32 or signed-64
// LEB128 number, or one instruction); the block answers with its bytes, one output
// transaction per byte, the final byte of the request marked by m_tlast and each
// byte tagged with a wrapping 32-bit stream offset. A request emits 1 to 11 bytes;
// unused action codes are accepted and emit nothing. The sequencer fills the
// single output byte register once per cycle while that register is free;
// s_tready rises again once the last byte of a request has been loaded into that
// register, so the next request is taken while the last byte waits.
`include "wasm_instruction_leb128_encoder_core_macros.svh"

module wasm_instruction_leb128_encoder_core
  import wleb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // action [5:0], operand [69:6], zero pad
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // out_byte [7:0], byte_position [39:8]
  output logic                   m_tlast    // last_byte
);

  logic [5:0]         action;
  logic signed [63:0] operand;
  cmd_t               cmd;
  stat_t              stat;

  assign action  = s_tdata[5:0];
  assign operand = s_tdata[69:6];

  wleb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .action   (action),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wleb_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .action   (action),
    .operand  (operand),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A request that emits bytes holds off the next one.
  `WLEB_ASSERT_NEXT(a_busy_after_request,
    s_tvalid && s_tready && (s_tdata[5:0] <= ACT_SINGLE_LAST), !s_tready,
    "encoder ready again right after a request that emits bytes")

  // While idle, a pending output byte can only be the final byte of a request.
  `WLEB_ASSERT_SAME(a_idle_pending_is_last, s_tready && m_tvalid, m_tlast,
    "encoder idle with a non-final byte still pending")

  // Back-to-back bytes carry consecutive stream offsets.
  `WLEB_ASSERT_SAME(a_position_step,
    $past(m_tvalid && m_tready && !rst) && m_tvalid && !$past(rst),
    m_tdata[39:8] == $past(m_tdata[39:8]) + 32'd1,
    "stream offset did not advance by one between bytes")

endmodule
